@@ src/i2cms_pkg.sv @@
// i2cms_pkg: item types and codes shared by the i2c master bit sequencer
// no dependencies; imported by i2cms_core and i2c_master_bit_sequencer

package i2cms_pkg;

    localparam logic [2:0] KIND_TICK     = 3'd0;
    localparam logic [2:0] KIND_START    = 3'd1;
    localparam logic [2:0] KIND_STOP     = 3'd2;
    localparam logic [2:0] KIND_WRITE    = 3'd3;
    localparam logic [2:0] KIND_READ_ACK = 3'd4;
    localparam logic [2:0] KIND_READ_NAK = 3'd5;

    localparam logic [15:0] HALF_PERIOD_RESET = 16'd10;

    // last step index of each command
    localparam logic [5:0] START_LAST = 6'd2;
    localparam logic [5:0] STOP_LAST  = 6'd3;
    localparam logic [5:0] WRITE_LAST = 6'd18;
    localparam logic [5:0] READ_LAST  = 6'd27;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data_byte;
        logic       sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       acked;
        logic       rejected;
    } res_item_t;

endpackage

@@ src/i2c_master_bit_sequencer.sv @@
// i2c_master_bit_sequencer: top level with input register, core and result register
// depends on i2cms_pkg and i2cms_core
//
//  channel | signals                        | direction
//  cmd     | cmd_valid cmd_ready cmd_item   | item in (kind, data_byte, sda_in)
//  res     | res_valid res_ready res_item   | one result item per command item
//  cfg     | cfg_valid cfg_ready cfg_data   | half_period write, always ready
//
// one item per cycle sustained while results are taken; each item lands in the input register,
// then the core updates its state and the result register together
// a stalled result register holds the core and the input register back
// reset clears both valid flags, pins to released and half_period to 10

module i2c_master_bit_sequencer
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_item_t   cmd_item,
    output logic        res_valid,
    input  logic        res_ready,
    output res_item_t   res_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic        cmd_vld_reg;
    cmd_item_t   cmd_item_reg;
    logic        res_vld_reg;
    res_item_t   res_item_reg;
    logic [15:0] half_period_reg;
    logic        adv;
    res_item_t   core_res;

    assign adv       = cmd_vld_reg && (!res_vld_reg || res_ready);
    assign cmd_ready = !cmd_vld_reg || adv;
    assign cfg_ready = 1'b1;
    assign res_valid = res_vld_reg;
    assign res_item  = res_item_reg;

    i2cms_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .item        (cmd_item_reg),
        .half_period (half_period_reg),
        .res         (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg     <= 1'b0;
            res_vld_reg     <= 1'b0;
            half_period_reg <= HALF_PERIOD_RESET;
        end
        else
        begin
            if (cmd_ready)
                cmd_vld_reg <= cmd_valid;
            if (adv)
                res_vld_reg <= 1'b1;
            else if (res_ready)
                res_vld_reg <= 1'b0;
            if (cfg_valid)
                half_period_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && cmd_ready)
            cmd_item_reg <= cmd_item;
        if (adv)
            res_item_reg <= core_res;
    end

endmodule

@@ src/i2cms_core.sv @@
// i2cms_core: command state, step sequencing and pin levels
// depends on i2cms_pkg; state advances on each item taken from the input register

module i2cms_core
    import i2cms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        adv,
    input  cmd_item_t   item,
    input  logic [15:0] half_period,
    output res_item_t   res
);

    logic [2:0]  held_reg,  held_next;
    logic [5:0]  step_reg,  step_next;
    logic [15:0] wait_reg,  wait_next;
    logic [7:0]  shift_reg, shift_next;
    logic        scl_reg,   scl_next;
    logic        sda_reg,   sda_next;
    logic        ack_reg,   ack_next;
    logic [7:0]  hold_reg,  hold_next;

    logic [15:0] wait_load;
    logic [5:0]  s;
    logic [1:0]  phase;
    logic        fin;
    logic        done;
    logic        rejected;

    assign wait_load = (half_period == 16'd0) ? 16'd1 : half_period;
    assign s = step_reg + 6'd1;

    // position within the three-step bit slot of a read
    always_comb
    begin
        case (s) inside
            6'd1, 6'd4, 6'd7, 6'd10, 6'd13, 6'd16, 6'd19, 6'd22: phase = 2'd0;
            6'd2, 6'd5, 6'd8, 6'd11, 6'd14, 6'd17, 6'd20, 6'd23: phase = 2'd1;
            default: phase = 2'd2;
        endcase
    end

    always_comb
    begin
        held_next  = held_reg;
        step_next  = step_reg;
        wait_next  = wait_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        ack_next   = ack_reg;
        hold_next  = hold_reg;
        fin        = 1'b0;
        done       = 1'b0;
        rejected   = 1'b0;

        if (item.kind == KIND_TICK)
        begin
            if (held_reg != KIND_TICK)
            begin
                if (wait_reg > 16'd1)
                begin
                    wait_next = wait_reg - 16'd1;
                end
                else
                begin
                    step_next = s;
                    case (held_reg)
                        KIND_START:
                        begin
                            if (s == 6'd1)
                                sda_next = 1'b0;
                            else
                            begin
                                scl_next = 1'b0;
                                fin = 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            if (s == 6'd1)
                                scl_next = 1'b1;
                            else if (s == 6'd2)
                                sda_next = 1'b1;
                            else
                                fin = 1'b1;
                        end
                        KIND_WRITE:
                        begin
                            if (s < 6'd16 && s[0])
                                scl_next = 1'b1;
                            else if (s < 6'd16)
                            begin
                                scl_next   = 1'b0;
                                shift_next = {shift_reg[6:0], 1'b0};
                                sda_next   = shift_reg[6];
                            end
                            else if (s == 6'd16)
                            begin
                                scl_next = 1'b0;
                                sda_next = 1'b1;
                            end
                            else if (s == 6'd17)
                            begin
                                scl_next = 1'b1;
                                ack_next = ~item.sda_in;
                            end
                            else
                            begin
                                scl_next = 1'b0;
                                fin = 1'b1;
                            end
                        end
                        KIND_READ_ACK, KIND_READ_NAK:
                        begin
                            if (s <= 6'd24)
                            begin
                                if (phase == 2'd0)
                                    scl_next = 1'b1;
                                else if (phase == 2'd1)
                                    shift_next = {shift_reg[6:0], item.sda_in};
                                else
                                    scl_next = 1'b0;
                            end
                            else if (s == 6'd25)
                                sda_next = (held_reg == KIND_READ_NAK);
                            else if (s == 6'd26)
                                scl_next = 1'b1;
                            else
                            begin
                                scl_next  = 1'b0;
                                hold_next = shift_reg;
                                fin = 1'b1;
                            end
                        end
                        default: fin = 1'b1;
                    endcase
                    if (fin)
                    begin
                        held_next = KIND_TICK;
                        step_next = 6'd0;
                        wait_next = 16'd0;
                        done      = 1'b1;
                    end
                    else
                    begin
                        wait_next = wait_load;
                    end
                end
            end
        end
        else if (item.kind <= KIND_READ_NAK)
        begin
            if (held_reg != KIND_TICK)
            begin
                rejected = 1'b1;
            end
            else
            begin
                held_next  = item.kind;
                step_next  = 6'd0;
                wait_next  = wait_load;
                shift_next = (item.kind == KIND_WRITE) ? item.data_byte : 8'd0;
                case (item.kind)
                    KIND_START:
                    begin
                        scl_next = 1'b1;
                        sda_next = 1'b1;
                    end
                    KIND_STOP:
                    begin
                        scl_next = 1'b0;
                        sda_next = 1'b0;
                    end
                    KIND_WRITE: sda_next = item.data_byte[7];
                    default:    sda_next = 1'b1;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= KIND_TICK;
            step_reg  <= 6'd0;
            wait_reg  <= 16'd0;
            shift_reg <= 8'd0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            ack_reg   <= 1'b0;
            hold_reg  <= 8'd0;
        end
        else if (adv)
        begin
            held_reg  <= held_next;
            step_reg  <= step_next;
            wait_reg  <= wait_next;
            shift_reg <= shift_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            ack_reg   <= ack_next;
            hold_reg  <= hold_next;
        end
    end

    assign res.scl_out   = scl_next;
    assign res.sda_out   = sda_next;
    assign res.busy_res  = (held_next != KIND_TICK);
    assign res.done_res  = done;
    assign res.read_byte = hold_next;
    assign res.acked     = ack_next;
    assign res.rejected  = rejected;

    // idle means no step or wait pending
    a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg == KIND_TICK) |-> (step_reg == 6'd0 && wait_reg == 16'd0))
        else $error("idle with step or wait pending");

    // a running command always has a wait loaded
    a_busy_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != KIND_TICK) |-> (wait_reg != 16'd0))
        else $error("busy with empty wait counter");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg < READ_LAST)
        else $error("step index past last step");

    // a refused command leaves the running sequence alone
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && rejected) |=> ($stable(step_reg) && $stable(wait_reg) && $stable(held_reg)))
        else $error("rejected command disturbed the sequence");

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for i2c_master_bit_sequencer, bus levels and status per item
// depends on i2cms_pkg and i2c_master_bit_sequencer; predicts every result item in place

module testbench;
    import i2cms_pkg::*;

    localparam int          CLK_HALF       = 4;
    localparam int          CYCLE_LIMIT    = 1_500_000;
    localparam int          REPORT_LIMIT   = 100;
    localparam logic [2:0]  NO_COMMAND     = KIND_TICK;
    localparam logic [2:0]  KIND_UNUSED_LO = 3'd6;
    localparam logic [2:0]  KIND_UNUSED_HI = 3'd7;

    logic        clk;
    logic        rst_n;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_item_t   cmd_item;
    logic        res_valid;
    logic        res_ready;
    res_item_t   res_item;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // predicted bus controller state
    logic [15:0] bus_half_period;
    logic [2:0]  bus_cmd;
    logic [5:0]  bus_step;
    logic [15:0] bus_wait;
    logic [7:0]  bus_shift;
    logic        bus_scl;
    logic        bus_sda;
    logic        bus_acked;
    logic [7:0]  bus_read_byte;

    res_item_t   expected_pins_q[$];
    res_item_t   want_res;

    int          mismatch_count;
    int          results_checked;
    int          active_items;
    int          commands_done;
    int          commands_refused;
    int          cycle_count;
    int          burst_left;
    bit          sender_idles;
    bit          stall_on;
    logic [15:0] ready_pattern;
    int          pattern_age;

    i2c_master_bit_sequencer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // one step of the running command, returns 1 when the command is finished
    function automatic logic bus_run_step(input logic [5:0] s, input logic sda_bit);
        int r;
        case (bus_cmd)
            KIND_START:
            begin
                if (s == 6'd0)
                begin
                    bus_scl = 1'b1;
                    bus_sda = 1'b1;
                    return 1'b0;
                end
                if (s == 6'd1)
                begin
                    bus_sda = 1'b0;
                    return 1'b0;
                end
                bus_scl = 1'b0;
                return 1'b1;
            end
            KIND_STOP:
            begin
                if (s == 6'd0)
                begin
                    bus_scl = 1'b0;
                    bus_sda = 1'b0;
                    return 1'b0;
                end
                if (s == 6'd1)
                begin
                    bus_scl = 1'b1;
                    return 1'b0;
                end
                if (s == 6'd2)
                begin
                    bus_sda = 1'b1;
                    return 1'b0;
                end
                return 1'b1;
            end
            KIND_WRITE:
            begin
                if (s == 6'd0)
                begin
                    bus_sda = bus_shift[7];
                    return 1'b0;
                end
                if (s < 6'd16 && s[0])
                begin
                    bus_scl = 1'b1;
                    return 1'b0;
                end
                if (s < 6'd16)
                begin
                    bus_scl = 1'b0;
                    bus_shift = bus_shift << 1;
                    bus_sda = bus_shift[7];
                    return 1'b0;
                end
                if (s == 6'd16)
                begin
                    bus_scl = 1'b0;
                    bus_sda = 1'b1;
                    return 1'b0;
                end
                if (s == 6'd17)
                begin
                    bus_scl = 1'b1;
                    bus_acked = ~sda_bit;
                    return 1'b0;
                end
                bus_scl = 1'b0;
                return 1'b1;
            end
            KIND_READ_ACK, KIND_READ_NAK:
            begin
                if (s == 6'd0)
                begin
                    bus_sda = 1'b1;
                    return 1'b0;
                end
                if (s <= 6'd24)
                begin
                    r = (int'(s) - 1) % 3;
                    if (r == 0)
                        bus_scl = 1'b1;
                    else if (r == 1)
                        bus_shift = {bus_shift[6:0], sda_bit};
                    else
                        bus_scl = 1'b0;
                    return 1'b0;
                end
                if (s == 6'd25)
                begin
                    bus_sda = (bus_cmd == KIND_READ_NAK);
                    return 1'b0;
                end
                if (s == 6'd26)
                begin
                    bus_scl = 1'b1;
                    return 1'b0;
                end
                bus_scl = 1'b0;
                bus_read_byte = bus_shift;
                return 1'b1;
            end
            default:
                return 1'b1;
        endcase
    endfunction

    function automatic res_item_t predict_bus_step(input cmd_item_t it);
        res_item_t   r;
        logic        done;
        logic        refused;
        logic [15:0] load;
        done = 1'b0;
        refused = 1'b0;
        load = (bus_half_period == 16'd0) ? 16'd1 : bus_half_period;
        if (it.kind == KIND_TICK)
        begin
            if (bus_cmd != NO_COMMAND)
            begin
                if (bus_wait > 16'd1)
                    bus_wait = bus_wait - 16'd1;
                else
                begin
                    bus_step = bus_step + 6'd1;
                    if (bus_run_step(bus_step, it.sda_in))
                    begin
                        bus_cmd = NO_COMMAND;
                        bus_step = 6'd0;
                        bus_wait = 16'd0;
                        done = 1'b1;
                    end
                    else
                        bus_wait = load;
                end
            end
        end
        else if (it.kind <= KIND_READ_NAK)
        begin
            if (bus_cmd != NO_COMMAND)
                refused = 1'b1;
            else
            begin
                bus_cmd = it.kind;
                bus_step = 6'd0;
                bus_shift = (it.kind == KIND_WRITE) ? it.data_byte : 8'h00;
                void'(bus_run_step(6'd0, it.sda_in));
                bus_wait = load;
            end
        end
        r.scl_out   = bus_scl;
        r.sda_out   = bus_sda;
        r.busy_res  = (bus_cmd != NO_COMMAND);
        r.done_res  = done;
        r.read_byte = bus_read_byte;
        r.acked     = bus_acked;
        r.rejected  = refused;
        return r;
    endfunction

    function automatic cmd_item_t random_item();
        cmd_item_t it;
        it.kind      = 3'($urandom_range(KIND_TICK, KIND_UNUSED_HI));
        it.data_byte = 8'($urandom_range(0, 255));
        it.sda_in    = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(input cmd_item_t it);
        int        gap;
        res_item_t r;
        if (burst_left == 0)
        begin
            gap = sender_idles ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                @(negedge clk);
                cmd_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = sender_idles ? $urandom_range(1, 20) : 1000;
        end
        @(negedge clk);
        cmd_valid <= 1'b1;
        cmd_item  <= it;
        do @(posedge clk); while (!cmd_ready);
        burst_left--;
        if ((it.kind != KIND_TICK || bus_cmd != NO_COMMAND) && it.kind <= KIND_READ_NAK)
            active_items++;
        r = predict_bus_step(it);
        if (r.done_res)
            commands_done++;
        if (r.rejected)
            commands_refused++;
        expected_pins_q.push_back(r);
    endtask

    task automatic release_cmd();
        @(negedge clk);
        cmd_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic drain_results();
        release_cmd();
        while (expected_pins_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_half_period(input logic [15:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        bus_half_period = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_kind(input logic [2:0] kind, input logic [7:0] data, input logic sda);
        cmd_item_t it;
        it.kind      = kind;
        it.data_byte = data;
        it.sda_in    = sda;
        send_item(it);
    endtask

    task automatic tick_until_idle();
        while (bus_cmd != NO_COMMAND)
            send_kind(KIND_TICK, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_idle_items();
        send_kind(KIND_TICK, 8'hFF, 1'b1);
        send_kind(KIND_TICK, 8'h00, 1'b0);
        send_kind(KIND_UNUSED_LO, 8'hFF, 1'b0);
        send_kind(KIND_UNUSED_HI, 8'h00, 1'b1);
    endtask

    task automatic test_start_stop();
        // start at the reset half period
        send_kind(KIND_START, 8'h00, 1'b1);
        tick_until_idle();
        set_half_period(16'd1);
        send_kind(KIND_STOP, 8'hFF, 1'b0);
        send_kind(KIND_WRITE, 8'hFF, 1'b1);
        send_kind(KIND_UNUSED_HI, 8'h5A, 1'b0);
        send_kind(KIND_TICK, 8'h00, 1'b0);
        send_kind(KIND_READ_NAK, 8'h00, 1'b0);
        tick_until_idle();
    endtask

    task automatic test_zero_half_period();
        set_half_period(16'd0);
        send_kind(KIND_START, 8'h00, 1'b0);
        tick_until_idle();
    endtask

    task automatic test_long_half_period();
        set_half_period(16'd50);
        sender_idles = 1'b0;
        stall_on = 1'b0;
        send_kind(KIND_START, 8'h00, 1'b1);
        tick_until_idle();
    endtask

    task automatic test_random_traffic(input int n_items, input bit with_idling);
        int        first;
        int        pick;
        cmd_item_t it;
        sender_idles = with_idling;
        stall_on = with_idling;
        first = active_items;
        while (active_items - first < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                it = random_item();
                it.kind = 3'($urandom_range(KIND_START, KIND_READ_NAK));
                send_item(it);
                while (bus_cmd != NO_COMMAND)
                begin
                    it = random_item();
                    pick = $urandom_range(0, 99);
                    if (pick < 4)
                        it.kind = 3'($urandom_range(KIND_START, KIND_READ_NAK));
                    else if (pick >= 6)
                        it.kind = KIND_TICK;
                    else
                        it.kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                    send_item(it);
                end
            end
            else
                send_item(random_item());
        end
    endtask

    task automatic check_field(input string name, input int want_v, input int got_v);
        if (want_v != got_v)
        begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $error("%s expected %0d got %0d", name, want_v, got_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_pins_q.size() == 0)
            begin
                mismatch_count++;
                $error("result item with nothing expected");
            end
            else
            begin
                want_res = expected_pins_q.pop_front();
                check_field("scl_out", int'(want_res.scl_out), int'(res_item.scl_out));
                check_field("sda_out", int'(want_res.sda_out), int'(res_item.sda_out));
                check_field("busy_res", int'(want_res.busy_res), int'(res_item.busy_res));
                check_field("done_res", int'(want_res.done_res), int'(res_item.done_res));
                check_field("read_byte", int'(want_res.read_byte),
                            int'(res_item.read_byte));
                check_field("acked", int'(want_res.acked), int'(res_item.acked));
                check_field("rejected", int'(want_res.rejected), int'(res_item.rejected));
                results_checked++;
            end
        end
    end

    // receiver stalls follow a rotating pattern that is reloaded now and then
    always @(negedge clk)
    begin
        res_ready <= !stall_on || ready_pattern[0];
        if (pattern_age == 63)
        begin
            ready_pattern <= 16'($urandom_range(0, 65535)) | 16'h0101;
            pattern_age <= 0;
        end
        else
        begin
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            pattern_age <= pattern_age + 1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        cmd_item = '0;
        res_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        ready_pattern = 16'hB5A7;
        pattern_age = 0;
        cycle_count = 0;
        mismatch_count = 0;
        results_checked = 0;
        active_items = 0;
        commands_done = 0;
        commands_refused = 0;
        burst_left = 0;
        sender_idles = 1'b1;
        stall_on = 1'b1;
        bus_half_period = HALF_PERIOD_RESET;
        bus_cmd = NO_COMMAND;
        bus_step = 6'd0;
        bus_wait = 16'd0;
        bus_shift = 8'h00;
        bus_scl = 1'b1;
        bus_sda = 1'b1;
        bus_acked = 1'b0;
        bus_read_byte = 8'h00;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_idle_items();
        test_start_stop();
        test_zero_half_period();
        test_long_half_period();
        set_half_period(16'd1);
        test_random_traffic(250, 1'b1);
        set_half_period(16'd2);
        test_random_traffic(150, 1'b1);
        set_half_period(16'd3);
        test_random_traffic(120, 1'b0);
        set_half_period(16'd1);
        test_random_traffic(150, 1'b1);

        drain_results();
        repeat (8) @(posedge clk);
        $display("checked %0d result items over half periods 0, 1, 2, 3, 10 and 50",
                 results_checked);
        $display("%0d commands completed, %0d refused while busy",
                 commands_done, commands_refused);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
